/* design/spwq_pkg.sv */
// ============================================================================
// spwq_pkg
// Shared types and codes for the staged priority work queue.
// ============================================================================
package spwq_pkg;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned ID_W    = 6;
    localparam int unsigned PRIO_W  = 3;
    localparam int unsigned STAGE_W = 3;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned CNT_W   = 7;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_SLOT_BUSY = 3'd3;
    localparam logic [STAT_W-1:0] ST_LIST_FULL = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    entry_id;
        logic [PRIO_W-1:0]  prio;
        logic [STAGE_W-1:0] stage_code;
        logic               unique_only;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]    out_id;
        logic [STAT_W-1:0]  status;
        logic [STAGE_W-1:0] current_stage;
        logic               still_active;
        logic [CNT_W-1:0]   stage_count;
    } result_t;

endpackage

/* design/staged_priority_work_queue.sv */
// ============================================================================
// staged_priority_work_queue
// Strict-priority table of work entries, each with an ordered stage list.
// ============================================================================
// Usage: drive cmd with start high; the beat is taken when busy is low.
// A two-deep command queue feeds an engine that executes one command at a
// time. Each command yields exactly one result beat, shown for one cycle
// with done high; the receiver cannot stall, so it must take it then.
// Each command passes through the read, execute and output states; next
// stage, when stages remain, also passes through a list read and a write.
// head scans every slot, one per cycle, before the output state. add stage
// walks the stage list, reading and checking each stage in turn, before
// the output state.
// Throughput is set by the engine: one command there at a time, so a new
// command is taken from the queue only once the last one is done.
// busy is high while the command queue is full.
// Reset clears all entries, the id rotation and the sequence counter; no
// clearing pass is needed.
// ============================================================================
module staged_priority_work_queue
#(
    parameter int unsigned ENTRIES          = 64,
    parameter int unsigned PRIO_LEVELS      = 8,
    parameter int unsigned NUM_STAGES       = 8,
    parameter int unsigned STAGES_PER_ENTRY = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  spwq_pkg::cmd_t    cmd,
    output logic              done,
    output spwq_pkg::result_t result
);

    logic           avail;
    logic           full;
    logic           pop;
    spwq_pkg::cmd_t head_cmd;

    assign busy = full;

    spwq_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (start && !full),
        .push_cmd (cmd),
        .pop      (pop),
        .avail    (avail),
        .full     (full),
        .head_cmd (head_cmd)
    );

    spwq_engine
    #(
        .ENTRIES          (ENTRIES),
        .PRIO_LEVELS      (PRIO_LEVELS),
        .NUM_STAGES       (NUM_STAGES),
        .STAGES_PER_ENTRY (STAGES_PER_ENTRY)
    )
    u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .avail  (avail),
        .cmd_in (head_cmd),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

/* design/spwq_front.sv */
// ============================================================================
// spwq_front
// Command intake: holds a short queue of accepted commands for the engine.
// ============================================================================
module spwq_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  spwq_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output logic            avail,
    output logic            full,
    output spwq_pkg::cmd_t  head_cmd
);

    spwq_pkg::cmd_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;

    assign avail    = cnt_reg != 2'd0;
    assign full     = cnt_reg == 2'd2;
    assign head_cmd = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= push_cmd;
    end

endmodule

/* design/spwq_engine.sv */
// ============================================================================
// spwq_engine
// Executes one command at a time against the entry table; head scans slots.
// ============================================================================
module spwq_engine
#(
    parameter int unsigned ENTRIES          = 64,
    parameter int unsigned PRIO_LEVELS      = 8,
    parameter int unsigned NUM_STAGES       = 8,
    parameter int unsigned STAGES_PER_ENTRY = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              avail,
    input  spwq_pkg::cmd_t    cmd_in,
    output logic              pop,
    output logic              done,
    output spwq_pkg::result_t result
);

    localparam int unsigned SW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned PW  = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
    localparam int unsigned LW  = $clog2(STAGES_PER_ENTRY + 1);
    localparam int unsigned IW  = (STAGES_PER_ENTRY > 1) ? $clog2(STAGES_PER_ENTRY) : 1;
    localparam int unsigned CW  = $clog2(ENTRIES + 1);
    localparam int unsigned SC  = spwq_pkg::STAGE_W;
    localparam int unsigned AW  = $clog2(ENTRIES * STAGES_PER_ENTRY);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_EXEC, S_SCAN, S_SCAN_WAIT, S_SCAN_LAST,
        S_NEXT_RD, S_NEXT_WR, S_LIST, S_LIST_CHK, S_OUT
    } state_t;

    // per-slot record; the stage list is a ring starting at hd
    typedef struct packed {
        logic [PW-1:0] prio;
        logic [SC-1:0] stage;
        logic [31:0]   stamp;
        logic [IW-1:0] hd;
        logic [LW-1:0] len;
    } meta_t;

    state_t state_reg;
    spwq_pkg::cmd_t c_reg;
    spwq_pkg::result_t res_reg;
    logic done_reg;

    logic [ENTRIES-1:0] valid_reg;
    meta_t              meta_mem [ENTRIES];
    logic [SC-1:0]      list_mem [ENTRIES*STAGES_PER_ENTRY];
    meta_t              meta_q;
    logic [SC-1:0]      list_q;
    logic [SW-1:0]      meta_raddr;
    logic [AW-1:0]      list_addr;

    logic               meta_we_reg;
    logic [SW-1:0]      meta_wa_reg;
    meta_t              meta_wd_reg;
    logic               list_we_reg;
    logic [AW-1:0]      list_wa_reg;
    logic [SC-1:0]      list_wd_reg;

    logic [SW-1:0]      idc_reg;
    logic [31:0]        seq_reg;
    logic [CW-1:0]      live_reg;

    logic [SW-1:0]      scan_reg;
    logic               pv_reg;
    logic               pval_reg;
    logic [SW-1:0]      pidx_reg;
    logic               found_reg;
    logic [SW-1:0]      best_reg;
    logic [PW-1:0]      bestp_reg;
    logic [31:0]        bestage_reg;
    logic [CW-1:0]      cnt_reg;
    logic [LW-1:0]      li_reg;
    logic [IW-1:0]      pos_reg;
    logic               present_reg;

    logic               id_ok;
    logic [SW-1:0]      sid;
    logic               stg_ok;
    logic [SW-1:0]      nid;
    logic [PW-1:0]      pclamp;
    logic [31:0]        age;
    logic               match;
    logic               better;
    logic [IW-1:0]      hd_inc;
    logic [IW-1:0]      pos_inc;

    assign id_ok  = ({26'd0, c_reg.entry_id} < 32'(ENTRIES)) && valid_reg[SW'(c_reg.entry_id)];
    assign sid    = SW'(c_reg.entry_id);
    assign stg_ok = {29'd0, c_reg.stage_code} < 32'(NUM_STAGES);
    assign nid    = (32'(idc_reg) == ENTRIES - 1) ? '0 : idc_reg + 1'b1;
    assign pclamp = ({29'd0, c_reg.prio} >= 32'(PRIO_LEVELS)) ? PW'(PRIO_LEVELS - 1)
                                                              : PW'(c_reg.prio);
    assign hd_inc  = (32'(meta_q.hd) + 32'd1 >= STAGES_PER_ENTRY) ? '0 : meta_q.hd + 1'b1;
    assign pos_inc = (32'(pos_reg) + 32'd1 >= STAGES_PER_ENTRY) ? '0 : pos_reg + 1'b1;

    assign meta_raddr = (state_reg == S_SCAN) ? scan_reg : sid;
    assign list_addr  = AW'(32'(sid) * STAGES_PER_ENTRY + 32'(pos_reg));

    assign age    = seq_reg - meta_q.stamp;
    assign match  = pval_reg && (meta_q.len != '0) && (meta_q.stage == c_reg.stage_code);
    assign better = !found_reg || (meta_q.prio < bestp_reg)
                    || (meta_q.prio == bestp_reg && age > bestage_reg);

    assign pop    = (state_reg == S_IDLE) && avail;
    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk)
    begin
        if (meta_we_reg)
            meta_mem[meta_wa_reg] <= meta_wd_reg;
        if (list_we_reg)
            list_mem[list_wa_reg] <= list_wd_reg;
        meta_q <= meta_mem[meta_raddr];
        list_q <= list_mem[list_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            valid_reg   <= '0;
            meta_we_reg <= 1'b0;
            list_we_reg <= 1'b0;
            pv_reg      <= 1'b0;
            idc_reg     <= '0;
            seq_reg     <= '0;
            live_reg    <= '0;
        end
        else
        begin
            done_reg    <= 1'b0;
            meta_we_reg <= 1'b0;
            list_we_reg <= 1'b0;
            if ((state_reg == S_SCAN || state_reg == S_SCAN_WAIT) && pv_reg && match)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (better)
                begin
                    found_reg   <= 1'b1;
                    best_reg    <= pidx_reg;
                    bestp_reg   <= meta_q.prio;
                    bestage_reg <= age;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (avail)
                    begin
                        c_reg     <= cmd_in;
                        res_reg   <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                    state_reg <= S_EXEC;
                S_EXEC:
                begin
                    state_reg <= S_OUT;
                    case (c_reg.cmd)
                        spwq_pkg::CMD_APPEND:
                        begin
                            if (!stg_ok)
                                res_reg.status <= spwq_pkg::ST_NOT_FOUND;
                            else if (32'(live_reg) >= ENTRIES)
                                res_reg.status <= spwq_pkg::ST_FULL;
                            else
                            begin
                                idc_reg <= nid;
                                res_reg.out_id <= spwq_pkg::ID_W'(nid);
                                if (valid_reg[nid])
                                    res_reg.status <= spwq_pkg::ST_SLOT_BUSY;
                                else
                                begin
                                    valid_reg[nid]    <= 1'b1;
                                    meta_we_reg       <= 1'b1;
                                    meta_wa_reg       <= nid;
                                    meta_wd_reg.prio  <= pclamp;
                                    meta_wd_reg.stage <= c_reg.stage_code;
                                    meta_wd_reg.stamp <= seq_reg;
                                    meta_wd_reg.hd    <= '0;
                                    meta_wd_reg.len   <= LW'(1);
                                    list_we_reg       <= 1'b1;
                                    list_wa_reg       <= AW'(32'(nid) * STAGES_PER_ENTRY);
                                    list_wd_reg       <= c_reg.stage_code;
                                    seq_reg           <= seq_reg + 32'd1;
                                    live_reg          <= live_reg + 1'b1;
                                end
                            end
                        end
                        spwq_pkg::CMD_HEAD:
                        begin
                            if (!stg_ok)
                                res_reg.status <= spwq_pkg::ST_NOT_FOUND;
                            else
                            begin
                                scan_reg  <= '0;
                                pv_reg    <= 1'b0;
                                found_reg <= 1'b0;
                                cnt_reg   <= '0;
                                state_reg <= S_SCAN;
                            end
                        end
                        spwq_pkg::CMD_NEXT:
                        begin
                            if (!id_ok)
                                res_reg.status <= spwq_pkg::ST_NOT_FOUND;
                            else if (meta_q.len <= LW'(1))
                            begin
                                valid_reg[sid] <= 1'b0;
                                live_reg       <= live_reg - 1'b1;
                            end
                            else
                            begin
                                pos_reg   <= hd_inc;
                                state_reg <= S_NEXT_RD;
                            end
                        end
                        spwq_pkg::CMD_ADD:
                        begin
                            if (!stg_ok || !id_ok)
                                res_reg.status <= spwq_pkg::ST_NOT_FOUND;
                            else
                            begin
                                li_reg      <= '0;
                                pos_reg     <= meta_q.hd;
                                present_reg <= 1'b0;
                                state_reg   <= S_LIST;
                            end
                        end
                        spwq_pkg::CMD_REMOVE:
                        begin
                            if (!id_ok)
                                res_reg.status <= spwq_pkg::ST_NOT_FOUND;
                            else
                            begin
                                valid_reg[sid] <= 1'b0;
                                live_reg       <= live_reg - 1'b1;
                            end
                        end
                        spwq_pkg::CMD_QUERY:
                        begin
                            if (!id_ok)
                                res_reg.status <= spwq_pkg::ST_NOT_FOUND;
                            else if (meta_q.len != '0)
                                res_reg.current_stage <= meta_q.stage;
                        end
                        spwq_pkg::CMD_CLEAR:
                        begin
                            valid_reg <= '0;
                            live_reg  <= '0;
                        end
                        default:
                            res_reg.status <= spwq_pkg::ST_NOT_FOUND;
                    endcase
                end
                S_SCAN:
                begin
                    pv_reg   <= 1'b1;
                    pidx_reg <= scan_reg;
                    pval_reg <= valid_reg[scan_reg];
                    if (32'(scan_reg) == ENTRIES - 1)
                        state_reg <= S_SCAN_WAIT;
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                S_SCAN_WAIT:
                    state_reg <= S_SCAN_LAST;
                S_SCAN_LAST:
                begin
                    res_reg.stage_count <= (32'(cnt_reg) > 127) ? 7'd127
                                                                : spwq_pkg::CNT_W'(cnt_reg);
                    if (found_reg)
                        res_reg.out_id <= spwq_pkg::ID_W'(best_reg);
                    else
                        res_reg.status <= spwq_pkg::ST_NOT_FOUND;
                    state_reg <= S_OUT;
                end
                S_NEXT_RD:
                    state_reg <= S_NEXT_WR;
                S_NEXT_WR:
                begin
                    meta_we_reg       <= 1'b1;
                    meta_wa_reg       <= sid;
                    meta_wd_reg.prio  <= meta_q.prio;
                    meta_wd_reg.stage <= list_q;
                    meta_wd_reg.stamp <= seq_reg;
                    meta_wd_reg.hd    <= pos_reg;
                    meta_wd_reg.len   <= meta_q.len - 1'b1;
                    seq_reg           <= seq_reg + 32'd1;
                    res_reg.still_active <= 1'b1;
                    state_reg         <= S_OUT;
                end
                S_LIST:
                begin
                    if (li_reg == meta_q.len)
                    begin
                        state_reg <= S_OUT;
                        if (!(c_reg.unique_only && present_reg))
                        begin
                            if (32'(meta_q.len) >= STAGES_PER_ENTRY)
                                res_reg.status <= spwq_pkg::ST_LIST_FULL;
                            else
                            begin
                                list_we_reg       <= 1'b1;
                                list_wa_reg       <= list_addr;
                                list_wd_reg       <= c_reg.stage_code;
                                meta_we_reg       <= 1'b1;
                                meta_wa_reg       <= sid;
                                meta_wd_reg.prio  <= meta_q.prio;
                                meta_wd_reg.stage <= meta_q.stage;
                                meta_wd_reg.stamp <= meta_q.stamp;
                                meta_wd_reg.hd    <= meta_q.hd;
                                meta_wd_reg.len   <= meta_q.len + 1'b1;
                            end
                        end
                    end
                    else
                        state_reg <= S_LIST_CHK;
                end
                S_LIST_CHK:
                begin
                    if (list_q == c_reg.stage_code)
                        present_reg <= 1'b1;
                    li_reg    <= li_reg + 1'b1;
                    pos_reg   <= pos_inc;
                    state_reg <= S_LIST;
                end
                S_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* design/spwq_checker.sv */
// ============================================================================
// spwq_checker
// Port-level checks on the staged priority work queue.
// ============================================================================
module spwq_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              done,
    input spwq_pkg::result_t result
);

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held two cycles");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status <= spwq_pkg::ST_LIST_FULL)
        else $error("bad status");

    a_active_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.still_active |-> result.status == spwq_pkg::ST_OK)
        else $error("still_active with error status");

    a_no_done_after_reset: assert property (@(posedge clk)
        !rst_n |=> !done && !busy)
        else $error("done or busy right after reset");

endmodule

bind staged_priority_work_queue spwq_checker u_spwq_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .done   (done),
    .result (result)
);
